>>> src/bsrv_pkg.sv
// ============================================================================
// bsrv_pkg
// Shared types, sizes and codes for the bounded stack with removal by value.
// ============================================================================
package bsrv_pkg;

    // Stack geometry and field widths.
    localparam int DEPTH    = 4;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 3;
    localparam int SPACE_W  = 3;
    localparam int FILL_W   = $clog2(DEPTH + 1);
    localparam int CNT_W    = $clog2(DEPTH);

    // Operation codes carried in the input item.
    typedef enum logic {
        OP_ARRIVE = 1'b0,
        OP_DEPART = 1'b1
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_PUSHED    = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_REMOVED   = 3'd2,
        STAT_EMPTY     = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } state_t;

    // Input and result payloads.
    typedef struct packed {
        op_t             opcode;
        logic [ID_W-1:0] ident;
    } in_item_t;

    typedef struct packed {
        status_t              status;
        logic [SPACE_W-1:0]   space_left;
    } out_item_t;

    // Control broadcast from the controller to every cell.
    typedef struct packed {
        logic scan_clr;
        logic scan_en;
        logic apply;
        logic any_hit;
    } cell_ctrl_t;

    // Free space for a given fill count, reduced to the result field width.
    function automatic logic [SPACE_W-1:0] space_code(input logic [FILL_W-1:0] fill);
        int s;
        s = DEPTH - int'(fill);
        return SPACE_W'(s);
    endfunction

endpackage

>>> src/bsrv_cell.sv
// ============================================================================
// bsrv_cell
// One stack slot: holds an identifier, compares it with the search key and
// passes a "match somewhere above" flag down to its lower neighbor.
// ============================================================================
module bsrv_cell
    import bsrv_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  cell_ctrl_t      ctrl,
    input  logic            valid,
    input  logic [ID_W-1:0] key,
    input  logic            wr_en,
    input  logic [ID_W-1:0] wr_data,
    input  logic [ID_W-1:0] nb_data,
    input  logic            nb_above,
    input  logic            nb_match,
    output logic [ID_W-1:0] data,
    output logic            match,
    output logic            above
);

    logic [ID_W-1:0] entry_reg;
    logic            above_reg;

    // A live slot whose identifier equals the key is a match.
    assign match = valid && (entry_reg == key);
    assign data  = entry_reg;
    assign above = above_reg;

    // The above flag ripples one cell down per scan cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            above_reg <= 1'b0;
        end else if (ctrl.scan_clr) begin
            above_reg <= 1'b0;
        end else if (ctrl.scan_en) begin
            above_reg <= nb_above | nb_match;
        end
    end

    // A push writes this slot; a removal at or below this slot pulls the
    // entry from the slot above.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg <= wr_data;
        end else if (ctrl.apply && ctrl.any_hit && !above_reg) begin
            entry_reg <= nb_data;
        end
    end

endmodule

>>> src/bounded_stack_remove_by_value.sv
// ============================================================================
// bounded_stack_remove_by_value
// Bounded LIFO stack of identifiers with removal of the topmost match.
// ============================================================================
// Each transfer on the input channel yields exactly one result transfer. An
// arrive, or a depart on an empty stack, is finished in the cycle it is
// accepted. A depart on a non-empty stack starts the search in the cycle
// it is accepted, lets the match flag ripple down the row of cells one
// slot per cycle in S_SCAN, and in S_APPLY shifts the entries above the
// removed slot down and registers the result. Items are handled one at a
// time, and the next item is taken as soon as the result register is free
// or is being emptied in the same cycle.
module bounded_stack_remove_by_value
    import bsrv_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [ID_W-1:0]   key_reg, key_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_item_reg, m_item_next;

    cell_ctrl_t        ctrl;
    logic              in_fire;
    logic              out_free;
    logic              full;
    logic              empty;
    logic              cnt_last;
    logic              push_ok;

    logic [ID_W-1:0]   cell_data  [DEPTH];
    logic              cell_match [DEPTH];
    logic              cell_above [DEPTH];

    assign out_free = !m_valid_reg || m_ready;
    assign in_fire  = s_valid && s_ready;
    assign full     = (fill_reg == FILL_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign cnt_last = (cnt_reg == CNT_W'(DEPTH - 2));
    assign push_ok  = in_fire && (s_item.opcode == OP_ARRIVE) && !full;

    // Row of cells; the top cell sees an empty neighbor.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [ID_W-1:0] nb_data;
        logic            nb_above;
        logic            nb_match;

        if (i == DEPTH - 1) begin : g_top
            assign nb_data  = '0;
            assign nb_above = 1'b0;
            assign nb_match = 1'b0;
        end else begin : g_mid
            assign nb_data  = cell_data[i+1];
            assign nb_above = cell_above[i+1];
            assign nb_match = cell_match[i+1];
        end

        bsrv_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .valid    (fill_reg > FILL_W'(i)),
            .key      (key_reg),
            .wr_en    (push_ok && (fill_reg == FILL_W'(i))),
            .wr_data  (s_item.ident),
            .nb_data  (nb_data),
            .nb_above (nb_above),
            .nb_match (nb_match),
            .data     (cell_data[i]),
            .match    (cell_match[i]),
            .above    (cell_above[i])
        );
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire && (s_item.opcode == OP_DEPART) && !empty) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (cnt_last) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb begin
        s_ready       = 1'b0;
        ctrl.scan_clr = 1'b0;
        ctrl.scan_en  = 1'b0;
        ctrl.apply    = 1'b0;
        // A match exists if the bottom cell matches or saw one above it.
        ctrl.any_hit  = cell_match[0] || cell_above[0];
        unique case (state_reg)
            S_IDLE: begin
                s_ready       = out_free;
                ctrl.scan_clr = 1'b1;
            end
            S_SCAN: begin
                ctrl.scan_en = 1'b1;
            end
            S_APPLY: begin
                ctrl.apply = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Datapath: fill count, search key, scan counter and result register.
    always_comb begin
        fill_next    = fill_reg;
        key_next     = key_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;

        if (state_reg == S_IDLE) begin
            cnt_next = '0;
            key_next = s_item.ident;
            if (in_fire) begin
                if (s_item.opcode == OP_ARRIVE) begin
                    m_valid_next = 1'b1;
                    if (full) begin
                        m_item_next.status     = STAT_FULL;
                        m_item_next.space_left = space_code(fill_reg);
                    end else begin
                        fill_next              = fill_reg + FILL_W'(1);
                        m_item_next.status     = STAT_PUSHED;
                        m_item_next.space_left = space_code(fill_reg + FILL_W'(1));
                    end
                end else if (empty) begin
                    m_valid_next           = 1'b1;
                    m_item_next.status     = STAT_EMPTY;
                    m_item_next.space_left = space_code(fill_reg);
                end
            end
        end else if (state_reg == S_SCAN) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (state_reg == S_APPLY) begin
            m_valid_next = 1'b1;
            if (ctrl.any_hit) begin
                fill_next              = fill_reg - FILL_W'(1);
                m_item_next.status     = STAT_REMOVED;
                m_item_next.space_left = space_code(fill_reg - FILL_W'(1));
            end else begin
                m_item_next.status     = STAT_NOT_FOUND;
                m_item_next.space_left = space_code(fill_reg);
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // The result register is empty while a search is in flight.
    a_no_result_during_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN || state_reg == S_APPLY) |-> !m_valid_reg)
        else $error("result pending during a search");

    // The fill count never exceeds the stack depth.
    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(DEPTH))
        else $error("fill count above depth");

    // The final search step always produces a result.
    a_apply_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_APPLY) |=> m_valid_reg)
        else $error("search finished without a result");

    // An accepted push onto a stack with room grows it by one.
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        push_ok |=> (fill_reg == $past(fill_reg) + FILL_W'(1)))
        else $error("push did not grow the stack");

endmodule
